>>> hw/rtl/pmdt_pkg.sv
`default_nettype none

package pmdt_pkg;

    localparam int PERIOD_UNITS = 100;
    localparam int RING_DEPTH   = 8;
    localparam int RING_AW      = $clog2(RING_DEPTH);
    localparam int PHASE_W      = $clog2(PERIOD_UNITS);
    localparam int DATA_W       = 32;
    localparam int DIV_CNT_W    = $clog2(DATA_W);
    localparam int MAG_W        = 7;
    localparam int SPEED_W      = 8;
    localparam int REQ_W        = 16;
    localparam int KIND_W       = 2;
    localparam int CFG_IDX_W    = 1;
    localparam int SPEED_MAX    = 100;

    localparam logic [DATA_W-1:0] NUMERATOR_RESET = 32'd1000000;
    localparam logic [DATA_W-1:0] MIN_SPAN_RESET  = 32'd100;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_SET   = 2'd1,
        KIND_PULSE = 2'd2,
        KIND_QUERY = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUMERATOR = 1'd0,
        CFG_MIN_SPAN  = 1'd1
    } t_cfg_idx;

    // stamp ring control from the sequencer
    typedef struct packed {
        logic push;
        logic clear;
        logic rd;
    } t_ring_ctl;

    typedef struct packed {
        logic pwm;
        logic in1;
        logic in2;
    } t_pins;

endpackage

`default_nettype wire

>>> hw/rtl/pmdt_in_if.sv
`default_nettype none

interface pmdt_in_if;
    import pmdt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [REQ_W-1:0]  speed_request;

    modport source (output valid, output kind, output speed_request, input ready);
    modport sink   (input valid, input kind, input speed_request, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pmdt_out_if.sv
`default_nettype none

interface pmdt_out_if;
    import pmdt_pkg::*;

    logic              valid;
    logic              ready;
    logic              pwm_level;
    logic              dir_in1;
    logic              dir_in2;
    logic [DATA_W-1:0] speed_value;

    modport source (output valid, output pwm_level, output dir_in1, output dir_in2,
                    output speed_value, input ready);
    modport sink   (input valid, input pwm_level, input dir_in1, input dir_in2,
                    input speed_value, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pmdt_div.sv
`default_nettype none

module pmdt_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pmdt_pkg::DATA_W-1:0]  i_dividend,
    input  logic [pmdt_pkg::DATA_W-1:0]  i_divisor,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [pmdt_pkg::DATA_W-1:0]  o_quotient
);
    import pmdt_pkg::*;

    logic [DATA_W-1:0]    r_rem, n_rem;
    logic [DATA_W-1:0]    r_quo, n_quo;
    logic [DATA_W-1:0]    r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DATA_W:0]      rem_sh;
    logic [DATA_W:0]      diff;
    logic                 ge;

    // restoring division, one quotient bit per cycle
    always_comb begin
        rem_sh = {r_rem, r_quo[DATA_W-1]};
        diff   = rem_sh - {1'b0, r_div};
        ge     = ~diff[DATA_W];
        n_rem  = ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
        n_quo  = {r_quo[DATA_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // done pulses for one cycle after the last step
            r_done <= !i_start && r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DATA_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

>>> hw/rtl/pmdt_ring.sv
`default_nettype none

module pmdt_ring (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pmdt_pkg::t_ring_ctl          i_ctl,
    input  logic [pmdt_pkg::DATA_W-1:0]  i_stamp,
    output logic [pmdt_pkg::DATA_W-1:0]  o_newest,
    output logic [pmdt_pkg::DATA_W-1:0]  o_oldest
);
    import pmdt_pkg::*;

    logic [DATA_W-1:0]     r_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_vld;
    logic [RING_AW-1:0]    r_slot;
    logic [RING_AW-1:0]    next_slot;
    logic [DATA_W-1:0]     r_rd_new;
    logic [DATA_W-1:0]     r_rd_old;

    assign next_slot = (r_slot == RING_AW'(RING_DEPTH - 1)) ? '0 : r_slot + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_slot <= '0;
        end else if (i_ctl.clear) begin
            r_vld  <= '0;
            r_slot <= '0;
        end else if (i_ctl.push) begin
            r_vld[next_slot] <= 1'b1;
            r_slot           <= next_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[next_slot] <= i_stamp;
        end
        // entries not written since the last clear read as zero
        if (i_ctl.rd) begin
            r_rd_new <= r_vld[r_slot] ? r_mem[r_slot] : '0;
            r_rd_old <= r_vld[next_slot] ? r_mem[next_slot] : '0;
        end
    end

    assign o_newest = r_rd_new;
    assign o_oldest = r_rd_old;

endmodule

`default_nettype wire

>>> hw/rtl/pmdt_pwm.sv
`default_nettype none

module pmdt_pwm (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_tick,
    input  logic                               i_set,
    input  logic signed [pmdt_pkg::REQ_W-1:0]  i_request,
    output pmdt_pkg::t_pins                    o_pins
);
    import pmdt_pkg::*;

    logic signed [SPEED_W-1:0] r_setting, n_setting;
    logic [MAG_W-1:0]          r_mag, n_mag;
    logic [PHASE_W-1:0]        r_phase, n_phase;
    logic                      r_dir_pos, n_dir_pos;
    t_pins                     r_pins, n_pins;
    logic signed [SPEED_W-1:0] neg_setting;
    logic signed [SPEED_W-1:0] clamped;

    always_comb begin
        neg_setting = -r_setting;
        if (i_request > REQ_W'(SPEED_MAX)) begin
            clamped = SPEED_W'(SPEED_MAX);
        end else if (i_request < -REQ_W'(SPEED_MAX)) begin
            clamped = -SPEED_W'(SPEED_MAX);
        end else begin
            clamped = i_request[SPEED_W-1:0];
        end

        n_setting = r_setting;
        n_mag     = r_mag;
        n_phase   = r_phase;
        n_dir_pos = r_dir_pos;
        n_pins    = r_pins;

        if (i_set) begin
            n_setting = clamped;
        end
        if (i_tick) begin
            // period start: latch magnitude, flip bridge only on a sign change
            if (r_phase == '0) begin
                n_mag = r_setting[SPEED_W-1] ? neg_setting[MAG_W-1:0]
                                             : r_setting[MAG_W-1:0];
                if (r_setting > 0 && !r_dir_pos) begin
                    n_pins.in1 = 1'b1;
                    n_pins.in2 = 1'b0;
                    n_dir_pos  = 1'b1;
                end else if (r_setting < 0 && r_dir_pos) begin
                    n_pins.in1 = 1'b0;
                    n_pins.in2 = 1'b1;
                    n_dir_pos  = 1'b0;
                end
            end
            n_pins.pwm = r_phase < PHASE_W'(n_mag);
            n_phase    = (r_phase == PHASE_W'(PERIOD_UNITS - 1)) ? '0 : r_phase + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setting <= '0;
            r_mag     <= '0;
            r_phase   <= '0;
            r_dir_pos <= 1'b1;
            r_pins    <= '{pwm: 1'b0, in1: 1'b0, in2: 1'b1};
        end else begin
            r_setting <= n_setting;
            r_mag     <= n_mag;
            r_phase   <= n_phase;
            r_dir_pos <= n_dir_pos;
            r_pins    <= n_pins;
        end
    end

    assign o_pins = r_pins;

endmodule

`default_nettype wire

>>> hw/rtl/pwm_motor_drive_with_tach.sv
`default_nettype none
// Tick, set speed and wheel pulse items pass from idle to the done state, then into the
// output register; a speed query goes through the span and check states and, unless the
// span is short, the 32-step divider. One item is handled at a time; the next item is
// taken once the current result is in the output register (an untaken result holds it).
// Reset (synchronous, active low): config registers to their defaults, stamp ring
// empty (reads as zero), tick clock and PWM period cleared, pins in1=0 in2=1 pwm=0.

module pwm_motor_drive_with_tach (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pmdt_in_if.sink                        i_in,
    pmdt_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [pmdt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pmdt_pkg::DATA_W-1:0]    i_cfg_wdata
);
    import pmdt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPAN,
        S_CHECK,
        S_DIV,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [DATA_W-1:0] r_numerator;
    logic [DATA_W-1:0] r_min_span;
    logic [DATA_W-1:0] r_tick_clock;
    logic [DATA_W-1:0] r_span;
    logic [DATA_W-1:0] r_value;
    logic              r_out_vld;
    t_pins             r_out_pins;
    logic [DATA_W-1:0] r_out_value;

    logic              in_fire;
    t_kind             kind;
    t_ring_ctl         ring_ctl;
    t_pins             pins;
    logic [DATA_W-1:0] stamp_new;
    logic [DATA_W-1:0] stamp_old;
    logic              div_start;
    logic              div_busy;
    logic              div_done;
    logic [DATA_W-1:0] div_quo;
    logic              out_free;
    logic              span_short;

    assign kind       = t_kind'(i_in.kind);
    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_vld || o_out.ready;
    assign span_short = (r_span == '0) || (r_span < r_min_span);
    assign div_start  = (r_state == S_CHECK) && !span_short;

    always_comb begin
        ring_ctl.push  = in_fire && (kind == KIND_PULSE);
        ring_ctl.clear = in_fire && (kind == KIND_SET) && (i_in.speed_request == '0);
        ring_ctl.rd    = in_fire && (kind == KIND_QUERY);
    end

    pmdt_ring u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ring_ctl),
        .i_stamp  (r_tick_clock),
        .o_newest (stamp_new),
        .o_oldest (stamp_old)
    );

    pmdt_pwm u_pwm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick    (in_fire && (kind == KIND_TICK)),
        .i_set     (in_fire && (kind == KIND_SET)),
        .i_request (i_in.speed_request),
        .o_pins    (pins)
    );

    pmdt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_numerator),
        .i_divisor  (r_span),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_numerator  <= NUMERATOR_RESET;
            r_min_span   <= MIN_SPAN_RESET;
            r_tick_clock <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_NUMERATOR: r_numerator <= i_cfg_wdata;
                    CFG_MIN_SPAN:  r_min_span  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (in_fire && (kind == KIND_TICK)) begin
                r_tick_clock <= r_tick_clock + 1'b1;
            end
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_value <= '0;
                        r_state <= (kind == KIND_QUERY) ? S_SPAN : S_DONE;
                    end
                end
                S_SPAN: begin
                    r_span  <= stamp_new - stamp_old;
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_state <= span_short ? S_DONE : S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_value <= div_quo;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_pins  <= pins;
                        r_out_value <= r_value;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.pwm_level   = r_out_pins.pwm;
    assign o_out.dir_in1     = r_out_pins.in1;
    assign o_out.dir_in2     = r_out_pins.in2;
    assign o_out.speed_value = r_out_value;

    a_bridge_pins_differ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pins.in1 != pins.in2)
        else $error("bridge direction pins equal");

    a_div_busy_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> (r_state == S_DIV))
        else $error("divider running outside the divide state");

    a_plain_item_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (kind != KIND_QUERY)) |=> (r_state == S_DONE))
        else $error("non-query item did not go straight to done");

    a_query_reads_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (kind == KIND_QUERY)) |=> (r_state == S_SPAN))
        else $error("query did not start the ring read");

endmodule

`default_nettype wire
